// File: rtl/cfsd_pkg.sv
// shared types and constants for the serial can frame deframer
package cfsd_pkg;

   // framing bytes and masks
   localparam logic [7:0] START_BYTE   = 8'hAA;
   localparam logic [7:0] TAIL_BYTE    = 8'h55;
   localparam logic [7:0] EXT_TOP_MASK = 8'h1F;
   localparam logic [7:0] STD_TOP_MASK = 8'h07;
   localparam int         EXT_BIT_POS  = 5;

   // identifier byte counts and the index of the top identifier byte
   localparam logic [3:0] STD_ID_BYTES = 4'd2;
   localparam logic [3:0] EXT_ID_BYTES = 4'd4;
   localparam logic [3:0] STD_ID_TOP   = 4'd1;
   localparam logic [3:0] EXT_ID_TOP   = 4'd3;

   // result status codes
   localparam logic [1:0] ST_GOOD     = 2'd0;
   localparam logic [1:0] ST_BAD_LEN  = 2'd1;
   localparam logic [1:0] ST_BAD_TAIL = 2'd2;

   // parser phases, one-hot
   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_INFO = 5'b00010,
      PH_ID   = 5'b00100,
      PH_DATA = 5'b01000,
      PH_TAIL = 5'b10000
   } phase_type;

   // one decoded frame result
   typedef struct packed {
      logic [1:0]  status;
      logic [28:0] frame_id;
      logic        extended;
      logic [3:0]  dlc;
      logic [63:0] payload;
   } result_type;

endpackage

// File: rtl/cfsd_parser.sv
// byte-at-a-time frame parser state and next-state logic
module cfsd_parser
   import cfsd_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_take,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   localparam logic [4:0] MaxLen = 5'(MAX_DATA_BYTES);

   phase_type   phase_ff,   phase_in;
   logic [3:0]  count_ff,   count_in;
   logic [28:0] id_ff,      id_in;
   logic        ext_ff,     ext_in;
   logic [3:0]  len_ff,     len_in;
   logic [63:0] pay_ff,     pay_in;

   logic [7:0]  id_byte;
   logic [31:0] id_wide;
   logic [3:0]  count_inc;
   logic [3:0]  id_total;

   // next state and result for the byte being taken
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      id_in     = id_ff;
      ext_in    = ext_ff;
      len_in    = len_ff;
      pay_in    = pay_ff;
      res_valid = 1'b0;
      res.status   = ST_GOOD;
      res.frame_id = id_ff;
      res.extended = ext_ff;
      res.dlc      = len_ff;
      res.payload  = pay_ff;
      count_inc = count_ff + 4'd1;
      id_total  = ext_ff ? EXT_ID_BYTES : STD_ID_BYTES;

      // mask the top identifier byte down to the id width
      id_byte = rx_byte;
      if (ext_ff && count_ff == EXT_ID_TOP) begin
         id_byte = rx_byte & EXT_TOP_MASK;
      end else if (!ext_ff && count_ff == STD_ID_TOP) begin
         id_byte = rx_byte & STD_TOP_MASK;
      end
      id_wide = {3'b000, id_ff};
      id_wide[8 * count_ff[1:0] +: 8] = id_wide[8 * count_ff[1:0] +: 8] | id_byte;

      if (byte_take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == START_BYTE) begin
                  phase_in = PH_INFO;
               end
            end
            PH_INFO: begin
               len_in   = rx_byte[3:0];
               ext_in   = rx_byte[EXT_BIT_POS];
               id_in    = '0;
               pay_in   = '0;
               count_in = '0;
               if ({1'b0, rx_byte[3:0]} > MaxLen) begin
                  res_valid    = 1'b1;
                  res.status   = ST_BAD_LEN;
                  res.frame_id = '0;
                  res.extended = rx_byte[EXT_BIT_POS];
                  res.dlc      = rx_byte[3:0];
                  res.payload  = '0;
                  phase_in     = PH_HUNT;
               end else begin
                  phase_in = PH_ID;
               end
            end
            PH_ID: begin
               id_in    = id_wide[28:0];
               count_in = count_inc;
               if (count_inc == id_total) begin
                  count_in = '0;
                  phase_in = (len_ff == 4'd0) ? PH_TAIL : PH_DATA;
               end
            end
            PH_DATA: begin
               pay_in[8 * count_ff[2:0] +: 8] = pay_ff[8 * count_ff[2:0] +: 8] | rx_byte;
               count_in = count_inc;
               if (count_inc >= len_ff) begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               res_valid  = 1'b1;
               res.status = (rx_byte == TAIL_BYTE) ? ST_GOOD : ST_BAD_TAIL;
               phase_in   = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         ext_ff   <= 1'b0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         ext_ff   <= ext_in;
         len_ff   <= len_in;
      end
   end

   // accumulators, loaded at the info byte before use
   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      pay_ff <= pay_in;
   end

endmodule

// File: rtl/cfsd_rsp_reg.sv
// result register holding one frame result until taken
module cfsd_rsp_reg
   import cfsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_res,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic       slot_free,
   output result_type rsp_res
);

   logic       valid_ff, valid_in;
   result_type res_ff,   res_in;

   // load wins over drain, the slot is free when empty or being taken
   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = load_res;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_res   = res_ff;

endmodule

// File: rtl/can_serial_frame_deframer.sv
// top level: serial byte stream to can frame results
// a result appears in the cycle after the byte that completes or aborts a frame is taken
// throughput: one byte per cycle, limited only by the single result register
// a byte is refused only while an untaken result sits in the result register
// reset: synchronous, parser returns to hunting for the start byte, result slot empties
module can_serial_frame_deframer
   import cfsd_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [28:0] rsp_frame_id,
   output logic        rsp_extended,
   output logic [3:0]  rsp_dlc,
   output logic [63:0] rsp_payload
);

   logic       req_take;
   logic       res_valid;
   logic       slot_free;
   result_type res;
   result_type rsp_res;

   // request accepted when the result slot can take whatever it yields
   assign req_ready = slot_free;
   assign req_take  = req_valid && slot_free;

   cfsd_parser #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (req_take),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   cfsd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_res  (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .slot_free (slot_free),
      .rsp_res   (rsp_res)
   );

   // result fields
   assign rsp_status   = rsp_res.status;
   assign rsp_frame_id = rsp_res.frame_id;
   assign rsp_extended = rsp_res.extended;
   assign rsp_dlc      = rsp_res.dlc;
   assign rsp_payload  = rsp_res.payload;

endmodule

// File: test/can_frame_checker.sv
// checker for the can frame deframer: watches both channels, predicts and compares results
module can_frame_checker
   import cfsd_pkg::*;
#(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [28:0] rsp_frame_id,
   input  logic        rsp_extended,
   input  logic [3:0]  rsp_dlc,
   input  logic [63:0] rsp_payload,
   output int          fail_count,
   output int          frames_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow parser state
   phase_type   parse_phase;
   logic [3:0]  parse_count;
   logic [3:0]  len_seen;
   logic        ext_seen;
   logic [28:0] id_sum;
   logic [63:0] data_sum;

   result_type  expected_frames[$];
   result_type  want;
   int          fails = 0;

   // advance the shadow parser by one accepted byte, queue any frame it finishes
   task automatic parse_rx_byte(input logic [7:0] rx);
      logic [7:0]  id_byte;
      logic [31:0] id_part;
      logic [3:0]  id_total;
      result_type  frame;
      case (parse_phase)
         PH_HUNT: begin
            if (rx == START_BYTE) parse_phase = PH_INFO;
         end
         PH_INFO: begin
            len_seen    = rx[3:0];
            ext_seen    = rx[EXT_BIT_POS];
            id_sum      = '0;
            data_sum    = '0;
            parse_count = '0;
            if (len_seen > MAX_DATA_BYTES) begin
               // length over limit: report at once with empty id and payload
               frame.status   = ST_BAD_LEN;
               frame.frame_id = '0;
               frame.extended = ext_seen;
               frame.dlc      = len_seen;
               frame.payload  = '0;
               expected_frames.insert(expected_frames.size(), frame);
               parse_phase = PH_HUNT;
            end else begin
               parse_phase = PH_ID;
            end
         end
         PH_ID: begin
            id_total = ext_seen ? EXT_ID_BYTES : STD_ID_BYTES;
            id_byte  = rx;
            if (ext_seen && parse_count == EXT_ID_TOP) id_byte = rx & EXT_TOP_MASK;
            else if (!ext_seen && parse_count == STD_ID_TOP) id_byte = rx & STD_TOP_MASK;
            id_part     = 32'(id_byte) << (parse_count[1:0] * 8);
            id_sum      = id_sum | id_part[28:0];
            parse_count = parse_count + 4'd1;
            if (parse_count >= id_total) begin
               parse_count = '0;
               parse_phase = (len_seen == 4'd0) ? PH_TAIL : PH_DATA;
            end
         end
         PH_DATA: begin
            data_sum    = data_sum | (64'(rx) << (parse_count[2:0] * 8));
            parse_count = parse_count + 4'd1;
            if (parse_count >= len_seen) parse_phase = PH_TAIL;
         end
         PH_TAIL: begin
            // tail byte is consumed either way, never taken as a new start
            frame.status   = (rx == TAIL_BYTE) ? ST_GOOD : ST_BAD_TAIL;
            frame.frame_id = id_sum;
            frame.extended = ext_seen;
            frame.dlc      = len_seen;
            frame.payload  = data_sum;
            expected_frames.insert(expected_frames.size(), frame);
            parse_phase = PH_HUNT;
         end
         default: begin
            parse_phase = PH_HUNT;
         end
      endcase
   endtask

   // compare one field of a result
   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
         fails++;
      end
   endtask

   // results are checked before the request of the same edge is parsed
   always @(posedge clock) begin
      if (reset) begin
         parse_phase = PH_HUNT;
         parse_count = '0;
         len_seen    = '0;
         ext_seen    = 1'b0;
         id_sum      = '0;
         data_sum    = '0;
         expected_frames.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0h id %0h",
                        $time, rsp_status, rsp_frame_id);
               fails++;
            end else begin
               want = expected_frames.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("frame_id", 64'(want.frame_id), 64'(rsp_frame_id));
               check_field("extended", 64'(want.extended), 64'(rsp_extended));
               check_field("dlc", 64'(want.dlc), 64'(rsp_dlc));
               check_field("payload", want.payload, rsp_payload);
            end
         end
         if (req_valid && req_ready) parse_rx_byte(req_rx_byte);
      end
      fail_count  <= fails;
      frames_owed <= expected_frames.size();
   end

endmodule

// File: test/tb_can_serial_frame_deframer.sv
// testbench top for the can frame deframer: byte stimulus, receiver stalls and verdict
module tb_can_serial_frame_deframer
   import cfsd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [28:0] rsp_frame_id;
   logic        rsp_extended;
   logic [3:0]  rsp_dlc;
   logic [63:0] rsp_payload;

   int          fail_count;
   int          frames_owed;

   logic [7:0]  byte_stream[$];
   logic [15:0] rx_cycle = '0;
   logic        hold_off = 1'b0;
   int          hold_seen = 0;

   can_serial_frame_deframer dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_frame_id (rsp_frame_id),
      .rsp_extended (rsp_extended),
      .rsp_dlc      (rsp_dlc),
      .rsp_payload  (rsp_payload)
   );

   can_frame_checker frame_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_frame_id (rsp_frame_id),
      .rsp_extended (rsp_extended),
      .rsp_dlc      (rsp_dlc),
      .rsp_payload  (rsp_payload),
      .fail_count   (fail_count),
      .frames_owed  (frames_owed)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // append one byte to the stream
   task automatic add_byte(input logic [7:0] b);
      byte_stream.insert(byte_stream.size(), b);
   endtask

   // append a whole frame; spare info bits come from the spare argument
   task automatic add_frame(input logic ext, input logic [3:0] len, input logic [31:0] id_raw,
                            input logic [63:0] data, input logic [7:0] tail,
                            input logic [7:0] spare);
      int id_total;
      add_byte(START_BYTE);
      add_byte((spare & 8'hD0) | (8'(ext) << EXT_BIT_POS) | {4'h0, len});
      id_total = ext ? 4 : 2;
      for (int k = 0; k < id_total; k++) add_byte(id_raw[8*k +: 8]);
      for (int k = 0; k < len; k++) add_byte(data[8*k +: 8]);
      add_byte(tail);
   endtask

   // build the whole byte stream: directed part first, then random traffic
   task automatic build_stream;
      int pick;
      int n;
      logic [7:0] info;
      // noise while hunting, including a stray tail byte
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(TAIL_BYTE);
      // standard zero-length frame, all id bits set so the top byte gets masked
      add_frame(1'b0, 4'd0, 32'h0000_FFFF, 64'h0, TAIL_BYTE, 8'hFF);
      // start byte as info: extended, length over limit
      add_byte(START_BYTE);
      add_byte(START_BYTE);
      // length just over the limit
      add_byte(START_BYTE);
      add_byte(8'h09);
      // full extended frame, start bytes inside id and data, start byte as bad tail
      add_frame(1'b1, 4'd8, 32'hFFAA_FFFF, 64'hAA00_FF5A_A5AA_0180, START_BYTE, 8'h00);
      // standard one-byte frame whose data is a start byte
      add_frame(1'b0, 4'd1, 32'h0000_03AA, 64'hAA, TAIL_BYTE, 8'h10);
      // random traffic
      while (byte_stream.size() < 430) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            add_frame(1'($urandom_range(0, 1)), 4'($urandom_range(0, 8)), $urandom,
                      {$urandom, $urandom},
                      ($urandom_range(0, 9) == 0) ? 8'($urandom) : TAIL_BYTE,
                      8'($urandom));
         end else if (pick < 85) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) add_byte(8'($urandom));
         end else if (pick < 93) begin
            info = 8'($urandom);
            info[3:0] = 4'($urandom_range(9, 15));
            add_byte(START_BYTE);
            add_byte(info);
         end else begin
            // broken frame: cut short, the next bytes land in its fields
            info = 8'($urandom);
            info[3:0] = 4'($urandom_range(0, 8));
            add_byte(START_BYTE);
            add_byte(info);
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) add_byte(8'($urandom));
         end
      end
   endtask

   // receiver: ready pattern is chosen by rx_cycle[8:7], forced low during hold-off
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 16'd1;
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode_type'(rx_cycle[8:7]))
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= (rx_cycle[1:0] == 2'd0);
            default:   rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // long receiver hold-off once traffic is well under way, so the block backs up
   initial begin
      while (hold_seen < 120) begin
         @(posedge clock);
         if (!reset && req_valid && req_ready) hold_seen++;
      end
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // sender: bursts of requests with random gaps, then drain and verdict
   initial begin
      int burst_left;
      int gap;
      build_stream();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 24);
      for (int i = 0; i < byte_stream.size(); i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (i >= 150 && i < 250) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_valid   <= 1'b1;
         req_rx_byte <= byte_stream[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         burst_left--;
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
